// ===== rtl/core/altg_pkg.sv =====
// ----------------------------------------------------------------------------
// altg_pkg
// Shared types, constants and fixed-point helpers of the Legendre table
// generator: controller/datapath command word and saturating arithmetic.
// ----------------------------------------------------------------------------
package altg_pkg;

	localparam int VAL_W = 64;
	localparam int DEG_W = 4;
	localparam int K_W   = 7;

	typedef logic signed [VAL_W-1:0] q40_t;

	localparam q40_t VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q40_t VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam q40_t Q40_ONE = 64'sh0000_0100_0000_0000;
	localparam logic [VAL_W-1:0] HALF_RANGE = 64'h8000_0000_0000_0000;

	localparam logic signed [31:0] Q30_ONE  = 32'sh4000_0000;
	localparam logic signed [31:0] Q30_NEG  = -32'sh4000_0000;
	localparam logic signed [31:0] Q30_NEAR = 32'sh3FFF_FFFF;
	localparam logic signed [31:0] Q30_NEARN = -32'sh3FFF_FFFF;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_PREP,
		OP_CLR,
		OP_ONE,
		OP_RD,
		OP_MULQ,
		OP_MULK,
		OP_SUB,
		OP_NEG,
		OP_DIV,
		OP_MOV,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		SRC_ACC,
		SRC_RD,
		SRC_P,
		SRC_DP,
		SRC_HOLD,
		SRC_AUX
	} src_t;

	typedef enum logic [2:0] {
		DST_ACC,
		DST_HOLD,
		DST_AUX,
		DST_P,
		DST_DP,
		DST_D2
	} dst_t;

	typedef enum logic [1:0] {
		FAC_X,
		FAC_S,
		FAC_XC
	} fac_t;

	typedef struct packed {
		logic             start;
		logic             load_x;
		op_t              op;
		src_t             src;
		dst_t             dst;
		fac_t             fac;
		logic [K_W-1:0]   k;
		logic             scale;
		logic             flip;
		logic [DEG_W-1:0] rd_l;
		logic [DEG_W-1:0] rd_m;
		logic [DEG_W-1:0] ent_l;
		logic [DEG_W-1:0] ent_m;
		logic             last;
	} altg_cmd_t;

	typedef struct packed {
		logic done;
	} altg_sts_t;

	typedef struct packed {
		logic sat;
		q40_t val;
	} sres_t;

	function automatic logic [VAL_W-1:0] magn(input q40_t a);
		return a[VAL_W-1] ? (~a + 64'd1) : a;
	endfunction

	function automatic sres_t make_signed(input logic neg, input logic [VAL_W-1:0] m);
		sres_t r;
		r.sat = 1'b0;
		r.val = '0;
		if (neg) begin
			if (m > HALF_RANGE) begin
				r.sat = 1'b1;
				r.val = VAL_MIN;
			end else begin
				r.val = q40_t'(~m + 64'd1);
			end
		end else begin
			if (m >= HALF_RANGE) begin
				r.sat = 1'b1;
				r.val = VAL_MAX;
			end else begin
				r.val = q40_t'(m);
			end
		end
		return r;
	endfunction

	function automatic sres_t sat_sub(input q40_t a, input q40_t b);
		sres_t r;
		logic [VAL_W:0] d;
		d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		r.sat = 1'b0;
		r.val = q40_t'(d[VAL_W-1:0]);
		if (d[VAL_W] != d[VAL_W-1]) begin
			r.sat = 1'b1;
			r.val = d[VAL_W] ? VAL_MIN : VAL_MAX;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/altg_datapath.sv =====
// ----------------------------------------------------------------------------
// altg_datapath
// Register file, shared 32x32 multiplier, serial divider, square root and
// coefficient store; executes one command from the controller at a time.
// ----------------------------------------------------------------------------
module altg_datapath #(
	parameter int DEGREE_BOUND = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [31:0]  cos_value,
	input  altg_pkg::altg_cmd_t cmd,
	output altg_pkg::altg_sts_t sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          degree,
	output logic [3:0]          order,
	output logic signed [63:0]  poly_value,
	output logic signed [63:0]  first_deriv,
	output logic signed [63:0]  second_deriv,
	output logic                saturated,
	output logic                last
);
	import altg_pkg::*;

	localparam int STRIDE = DEGREE_BOUND + 1;
	localparam int DEPTH  = STRIDE * STRIDE;
	localparam int AW     = $clog2(DEPTH);
	localparam logic [6:0] PREP_LAST = 7'd33;
	localparam logic [6:0] DIV_LAST  = 7'd65;
	localparam logic [6:0] MULQ_LAST = 7'd3;

	altg_cmd_t cmd_q;
	logic       run_q;
	logic       done_q;
	logic [6:0] ph_q;

	logic signed [31:0] x_q;
	logic signed [31:0] xc_q;
	logic [30:0] s_q;
	logic [60:0] d_q;
	logic [62:0] v_q;
	logic [62:0] r_q;
	logic [62:0] bit_q;

	q40_t acc_q, hold_q, aux_q, rd_q, p_q, dp_q, d2_q;
	logic sat_q;

	logic [63:0] ma_q;
	logic [31:0] mb_q;
	logic        neg_q;
	logic [32:0] lo_q;
	logic [62:0] hi_q;

	logic [63:0] rem_q, lo_div_q, q_q, dv_q;

	logic [63:0] poly_mem [DEPTH];

	logic out_valid_q;
	logic [3:0] deg_q, ord_q;
	q40_t poly_q, fd_q, sd_q;
	logic osat_q, last_q;

	q40_t src_val;
	logic signed [31:0] fac_val;
	logic [31:0] fac_mag;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [31:0] xc_mag;
	logic [70:0] mk;
	logic [64:0] msum;
	logic [63:0] div_m, div_rem0, div_lo0, div_dv0;
	logic        div_neg, pre_ovf;
	logic [64:0] rs;
	logic        rs_ge;
	logic        rnd;
	logic [63:0] qf;
	logic [62:0] rb, nv, nr;
	logic [AW-1:0] rd_addr, wr_addr;
	sres_t res;
	logic  res_en;
	logic  fin;
	logic  emit_go;

	assign rd_addr = AW'(32'(cmd_q.rd_l) * STRIDE + 32'(cmd_q.rd_m));
	assign wr_addr = AW'(32'(cmd_q.ent_l) * STRIDE + 32'(cmd_q.ent_m));

	always_comb begin
		case (cmd_q.src)
			SRC_ACC:  src_val = acc_q;
			SRC_RD:   src_val = rd_q;
			SRC_P:    src_val = p_q;
			SRC_DP:   src_val = dp_q;
			SRC_HOLD: src_val = hold_q;
			SRC_AUX:  src_val = aux_q;
			default:  src_val = acc_q;
		endcase
		case (cmd_q.fac)
			FAC_X:   fac_val = x_q;
			FAC_S:   fac_val = {1'b0, s_q};
			FAC_XC:  fac_val = xc_q;
			default: fac_val = x_q;
		endcase
	end

	assign fac_mag = fac_val[31] ? (~fac_val + 32'd1) : fac_val;
	assign xc_mag  = xc_q[31] ? (~xc_q + 32'd1) : xc_q;

	always_comb begin
		if (cmd_q.op == OP_PREP) begin
			if (ph_q == 7'd0) begin
				mul_a = 32'h4000_0000 - x_q;
				mul_b = 32'h4000_0000 + x_q;
			end else begin
				mul_a = xc_mag;
				mul_b = xc_mag;
			end
		end else begin
			mul_a = (ph_q == 7'd1) ? ma_q[31:0] : ma_q[63:32];
			mul_b = mb_q;
		end
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign mk    = 71'(magn(src_val)) * 71'(cmd_q.k);
	assign msum  = {hi_q, 2'b00} + 65'(lo_q);

	assign div_m    = magn(acc_q);
	assign div_neg  = acc_q[63] ^ cmd_q.flip;
	assign div_rem0 = cmd_q.scale ? {4'b0, div_m[63:4]} : 64'd0;
	assign div_lo0  = cmd_q.scale ? {div_m[3:0], 60'd0} : div_m;
	assign div_dv0  = cmd_q.scale ? {3'b0, d_q} : {57'd0, cmd_q.k};
	assign pre_ovf  = div_rem0 >= div_dv0;
	assign rs       = {rem_q, lo_div_q[63]};
	assign rs_ge    = rs >= {1'b0, dv_q};
	assign rnd      = rem_q >= (dv_q - rem_q);
	assign qf       = q_q + 64'(rnd);

	assign rb = r_q + bit_q;
	always_comb begin
		if (v_q >= rb) begin
			nv = v_q - rb;
			nr = (r_q >> 1) + bit_q;
		end else begin
			nv = v_q;
			nr = r_q >> 1;
		end
	end

	assign emit_go = !out_valid_q || out_ready;

	always_comb begin
		res_en = 1'b0;
		res    = '0;
		fin    = 1'b1;
		case (cmd_q.op)
			OP_PREP: fin = (ph_q == PREP_LAST);
			OP_ONE: begin
				res_en  = 1'b1;
				res.val = Q40_ONE;
			end
			OP_MOV: begin
				res_en  = 1'b1;
				res.val = src_val;
			end
			OP_SUB: begin
				res_en = 1'b1;
				res    = sat_sub(acc_q, src_val);
			end
			OP_NEG: begin
				res_en = 1'b1;
				res    = sat_sub('0, acc_q);
			end
			OP_MULK: begin
				res_en = 1'b1;
				if (cmd_q.k == '0) begin
					res.val = '0;
				end else if (mk[70:64] != '0) begin
					res.sat = 1'b1;
					res.val = src_val[63] ? VAL_MIN : VAL_MAX;
				end else begin
					res = make_signed(src_val[63], mk[63:0]);
				end
			end
			OP_MULQ: begin
				fin = (ph_q == MULQ_LAST);
				if (fin) begin
					res_en = 1'b1;
					res    = make_signed(neg_q, msum[63:0]);
				end
			end
			OP_DIV: begin
				fin = 1'b0;
				if (ph_q == 7'd0 && pre_ovf) begin
					fin     = 1'b1;
					res_en  = 1'b1;
					res.sat = 1'b1;
					res.val = div_neg ? VAL_MIN : VAL_MAX;
				end else if (ph_q == DIV_LAST) begin
					fin    = 1'b1;
					res_en = 1'b1;
					if (rnd && (&q_q)) begin
						res.sat = 1'b1;
						res.val = neg_q ? VAL_MIN : VAL_MAX;
					end else begin
						res = make_signed(neg_q, qf);
					end
				end
			end
			OP_EMIT: fin = emit_go;
			default: fin = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			done_q      <= 1'b0;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.start) begin
				run_q <= 1'b1;
				ph_q  <= '0;
			end else if (run_q) begin
				if (fin) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
					if (cmd_q.op == OP_EMIT) begin
						out_valid_q <= 1'b1;
					end
				end else begin
					ph_q <= ph_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q <= cmd;
		end
		if (cmd.load_x) begin
			if (cos_value > Q30_ONE) begin
				x_q  <= Q30_ONE;
				xc_q <= Q30_NEAR;
			end else if (cos_value < Q30_NEG) begin
				x_q  <= Q30_NEG;
				xc_q <= Q30_NEARN;
			end else begin
				x_q <= cos_value;
				if (cos_value > Q30_NEAR) begin
					xc_q <= Q30_NEAR;
				end else if (cos_value < Q30_NEARN) begin
					xc_q <= Q30_NEARN;
				end else begin
					xc_q <= cos_value;
				end
			end
		end
		if (run_q) begin
			case (cmd_q.op)
				OP_PREP: begin
					if (ph_q == 7'd0) begin
						v_q <= 63'(mul_p[60:0]);
					end else if (ph_q == 7'd1) begin
						d_q   <= 61'h1000_0000_0000_0000 - mul_p[60:0];
						r_q   <= '0;
						bit_q <= 63'h4000_0000_0000_0000;
					end else begin
						v_q   <= nv;
						r_q   <= nr;
						bit_q <= bit_q >> 2;
						if (ph_q == PREP_LAST) begin
							s_q <= nr[30:0];
						end
					end
				end
				OP_CLR: begin
					sat_q <= 1'b0;
					dp_q  <= '0;
					d2_q  <= '0;
				end
				OP_RD: rd_q <= q40_t'(poly_mem[rd_addr]);
				OP_MULQ: begin
					if (ph_q == 7'd0) begin
						ma_q  <= magn(src_val);
						mb_q  <= fac_mag;
						neg_q <= src_val[63] ^ fac_val[31];
					end else if (ph_q == 7'd1) begin
						lo_q <= 33'((mul_p + 64'd536870912) >> 30);
					end else if (ph_q == 7'd2) begin
						hi_q <= mul_p[62:0];
					end
				end
				OP_DIV: begin
					if (ph_q == 7'd0) begin
						rem_q    <= div_rem0;
						lo_div_q <= div_lo0;
						dv_q     <= div_dv0;
						q_q      <= '0;
						neg_q    <= div_neg;
					end else if (ph_q != DIV_LAST) begin
						rem_q    <= rs_ge ? 64'(rs - {1'b0, dv_q}) : rs[63:0];
						q_q      <= {q_q[62:0], rs_ge};
						lo_div_q <= {lo_div_q[62:0], 1'b0};
					end
				end
				OP_EMIT: begin
					if (emit_go) begin
						deg_q  <= cmd_q.ent_l;
						ord_q  <= cmd_q.ent_m;
						poly_q <= p_q;
						fd_q   <= dp_q;
						sd_q   <= d2_q;
						osat_q <= sat_q;
						last_q <= cmd_q.last;
					end
				end
				default: ;
			endcase
			if (res_en) begin
				sat_q <= sat_q | res.sat;
				case (cmd_q.dst)
					DST_ACC:  acc_q  <= res.val;
					DST_HOLD: hold_q <= res.val;
					DST_AUX:  aux_q  <= res.val;
					DST_P:    p_q    <= res.val;
					DST_DP:   dp_q   <= res.val;
					DST_D2:   d2_q   <= res.val;
					default:  acc_q  <= res.val;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && res_en && cmd_q.dst == DST_P) begin
			poly_mem[wr_addr] <= res.val;
		end
	end

	assign sts.done     = done_q;
	assign out_valid    = out_valid_q;
	assign degree       = deg_q;
	assign order        = ord_q;
	assign poly_value   = poly_q;
	assign first_deriv  = fd_q;
	assign second_deriv = sd_q;
	assign saturated    = osat_q;
	assign last         = last_q;

endmodule

// ===== rtl/core/altg_ctrl.sv =====
// ----------------------------------------------------------------------------
// altg_ctrl
// Sequencer: walks the table degree-major and issues the micro-steps that
// build each entry's value and derivatives.
// ----------------------------------------------------------------------------
module altg_ctrl #(
	parameter int DEGREE_BOUND = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          max_degree,
	input  logic [1:0]          deriv_mode,
	output altg_pkg::altg_cmd_t cmd,
	input  altg_pkg::altg_sts_t sts
);
	import altg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_PREP_WAIT,
		S_STEP,
		S_WAIT
	} state_t;

	localparam logic [3:0] BOUND     = 4'(DEGREE_BOUND);
	localparam logic [4:0] LAST_STEP = 5'd26;
	localparam logic [1:0] MODE_VALUES = 2'd0;
	localparam logic [1:0] MODE_SECOND = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	state_t     state_q;
	logic [3:0] l_q, m_q, lmax_q;
	logic [1:0] mode_q;
	logic [4:0] step_q;

	logic orig, diag, gen, deriv_on, sub_on, d2_on;

	assign orig     = (l_q == 4'd0);
	assign diag     = !orig && (l_q == m_q);
	assign gen      = (5'(l_q) >= 5'(m_q) + 5'd2);
	assign deriv_on = (mode_q != MODE_VALUES) && !orig;
	assign sub_on   = deriv_on && (m_q < l_q);
	assign d2_on    = (mode_q == MODE_SECOND);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.op     = OP_NOP;
		cmd.src    = SRC_ACC;
		cmd.dst    = DST_ACC;
		cmd.fac    = FAC_X;
		cmd.ent_l  = l_q;
		cmd.ent_m  = m_q;
		cmd.last   = (l_q == lmax_q) && (m_q == l_q);
		cmd.load_x = (state_q == S_IDLE) && in_valid;
		if (state_q == S_PREP) begin
			cmd.op = OP_PREP;
		end else if (state_q == S_STEP) begin
			case (step_q)
				5'd0: cmd.op = OP_CLR;
				5'd1: begin
					if (orig) begin
						cmd.op = OP_ONE;
					end else begin
						cmd.op   = OP_RD;
						cmd.rd_l = l_q - 4'd1;
						cmd.rd_m = diag ? l_q - 4'd1 : m_q;
					end
				end
				5'd2: begin
					if (!orig) begin
						cmd.op  = OP_MULQ;
						cmd.src = SRC_RD;
						cmd.fac = diag ? FAC_S : FAC_X;
					end
				end
				5'd3: begin
					if (!orig) begin
						cmd.op = OP_MULK;
						cmd.k  = 7'({l_q, 1'b0}) - 7'd1;
					end
				end
				5'd4: begin
					if (diag) begin
						cmd.op = OP_NEG;
					end else if (gen) begin
						cmd.op   = OP_RD;
						cmd.rd_l = l_q - 4'd2;
						cmd.rd_m = m_q;
					end
				end
				5'd5: begin
					if (gen) begin
						cmd.op  = OP_MULK;
						cmd.src = SRC_RD;
						cmd.dst = DST_HOLD;
						cmd.k   = 7'(l_q) + 7'(m_q) - 7'd1;
					end
				end
				5'd6: begin
					if (gen) begin
						cmd.op  = OP_SUB;
						cmd.src = SRC_HOLD;
					end
				end
				5'd7: begin
					if (gen) begin
						cmd.op = OP_DIV;
						cmd.k  = 7'(l_q) - 7'(m_q);
					end
				end
				5'd8: begin
					cmd.op  = OP_MOV;
					cmd.dst = DST_P;
				end
				5'd9: begin
					if (deriv_on) begin
						cmd.op  = OP_MULQ;
						cmd.src = SRC_P;
						cmd.fac = FAC_XC;
					end
				end
				5'd10: begin
					if (deriv_on) begin
						cmd.op = OP_MULK;
						cmd.k  = 7'(l_q);
					end
				end
				5'd11: begin
					if (sub_on) begin
						cmd.op   = OP_RD;
						cmd.rd_l = l_q - 4'd1;
						cmd.rd_m = m_q;
					end
				end
				5'd12: begin
					if (sub_on) begin
						cmd.op  = OP_MULK;
						cmd.src = SRC_RD;
						cmd.dst = DST_HOLD;
						cmd.k   = 7'(l_q) + 7'(m_q);
					end
				end
				5'd13: begin
					if (sub_on) begin
						cmd.op  = OP_SUB;
						cmd.src = SRC_HOLD;
					end
				end
				5'd14: begin
					if (deriv_on) begin
						cmd.op    = OP_DIV;
						cmd.scale = 1'b1;
						cmd.flip  = 1'b1;
					end
				end
				5'd15: begin
					if (deriv_on) begin
						cmd.op  = OP_MOV;
						cmd.dst = DST_DP;
					end
				end
				5'd16: begin
					if (d2_on) begin
						cmd.op  = OP_MULK;
						cmd.src = SRC_P;
						cmd.k   = 7'(m_q) * 7'(m_q);
					end
				end
				5'd17: begin
					if (d2_on) begin
						cmd.op    = OP_DIV;
						cmd.scale = 1'b1;
						cmd.flip  = 1'b1;
					end
				end
				5'd18: begin
					if (d2_on) begin
						cmd.op  = OP_MOV;
						cmd.dst = DST_AUX;
					end
				end
				5'd19: begin
					if (d2_on) begin
						cmd.op  = OP_MULK;
						cmd.src = SRC_P;
						cmd.dst = DST_HOLD;
						cmd.k   = 7'(l_q) * (7'(l_q) + 7'd1);
					end
				end
				5'd20: begin
					if (d2_on) begin
						cmd.op  = OP_MULQ;
						cmd.src = SRC_DP;
						cmd.fac = FAC_XC;
					end
				end
				5'd21: begin
					if (d2_on) begin
						cmd.op = OP_MULK;
						cmd.k  = 7'd2;
					end
				end
				5'd22: begin
					if (d2_on) begin
						cmd.op  = OP_SUB;
						cmd.src = SRC_HOLD;
					end
				end
				5'd23: begin
					if (d2_on) begin
						cmd.op  = OP_SUB;
						cmd.src = SRC_AUX;
					end
				end
				5'd24: begin
					if (d2_on) begin
						cmd.op    = OP_DIV;
						cmd.scale = 1'b1;
					end
				end
				5'd25: begin
					if (d2_on) begin
						cmd.op  = OP_MOV;
						cmd.dst = DST_D2;
					end
				end
				5'd26: cmd.op = OP_EMIT;
				default: cmd.op = OP_NOP;
			endcase
		end
		cmd.start = (cmd.op != OP_NOP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			l_q     <= '0;
			m_q     <= '0;
			lmax_q  <= '0;
			mode_q  <= MODE_VALUES;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						lmax_q  <= (max_degree > BOUND) ? BOUND : max_degree;
						mode_q  <= (deriv_mode == MODE_UNUSED) ? MODE_SECOND : deriv_mode;
						l_q     <= '0;
						m_q     <= '0;
						step_q  <= '0;
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_PREP_WAIT;
				S_PREP_WAIT: begin
					if (sts.done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (cmd.op == OP_NOP) begin
						step_q <= step_q + 5'd1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (sts.done) begin
						state_q <= S_STEP;
						if (step_q == LAST_STEP) begin
							step_q <= '0;
							if (m_q == l_q) begin
								if (l_q == lmax_q) begin
									state_q <= S_IDLE;
								end else begin
									l_q <= l_q + 4'd1;
									m_q <= '0;
								end
							end else begin
								m_q <= m_q + 4'd1;
							end
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/assoc_legendre_table_gen.sv =====
// ----------------------------------------------------------------------------
// assoc_legendre_table_gen
// Takes one Q1.30 cosine per transaction and returns P(l,m) for l = 0 to
// max_degree and m = 0 to l, degree-major, in Q23.40, with dP/dx and the
// second-derivative expression when deriv_mode asks for them. One input is
// worked on at a time; in_ready is high only between tables. Setup runs a
// product, a square and a 32-step square root. After that, each entry runs
// its micro-steps in order and skips those that it does not need. Divisions
// run on the shared bit-serial divider: one for general entries, one more
// for dP, two more for the second derivative. A full table holds 45 entries
// at degree 8. The output register lets the next entry be worked on while
// one waits to be taken.
// ----------------------------------------------------------------------------
module assoc_legendre_table_gen #(
	parameter int DEGREE_BOUND = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] cos_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         degree,
	output logic [3:0]         order,
	output logic signed [63:0] poly_value,
	output logic signed [63:0] first_deriv,
	output logic signed [63:0] second_deriv,
	output logic               saturated,
	output logic               last
);
	import altg_pkg::*;

	localparam logic REG_MAX_DEGREE = 1'b0;
	localparam logic REG_DERIV_MODE = 1'b1;

	logic [3:0] max_degree_q;
	logic [1:0] deriv_mode_q;
	altg_cmd_t  cmd;
	altg_sts_t  sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DERIV_MODE) ? {30'd0, deriv_mode_q}
	                                             : {28'd0, max_degree_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= 4'd8;
			deriv_mode_q <= 2'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MAX_DEGREE) begin
				max_degree_q <= pwdata[3:0];
			end else begin
				deriv_mode_q <= pwdata[1:0];
			end
		end
	end

	altg_ctrl #(
		.DEGREE_BOUND(DEGREE_BOUND)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.max_degree(max_degree_q),
		.deriv_mode(deriv_mode_q),
		.cmd       (cmd),
		.sts       (sts)
	);

	altg_datapath #(
		.DEGREE_BOUND(DEGREE_BOUND)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cos_value   (cos_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.degree      (degree),
		.order       (order),
		.poly_value  (poly_value),
		.first_deriv (first_deriv),
		.second_deriv(second_deriv),
		.saturated   (saturated),
		.last        (last)
	);

endmodule
